// File: hdl/crr_pkg.sv
package crr_pkg;

  localparam int MaxStepsDefault = 1024;
  localparam int DataW = 32;
  localparam int StepsW = 11;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STEPS = 3'd0,
    REG_UP    = 3'd1,
    REG_DOWN  = 3'd2,
    REG_RATIO = 3'd3,
    REG_PROB  = 3'd4,
    REG_DISC  = 3'd5
  } cfg_reg_t;

  // factor applied by the price multiply
  typedef enum logic [1:0] {
    FSEL_DOWN  = 2'd0,
    FSEL_RATIO = 2'd1,
    FSEL_UP    = 2'd2
  } factor_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic start;       // latch spot/strike, clear saturation
    logic mul_go;      // start a price multiply
    factor_sel_t fsel; // factor: down, ratio or up
    logic psel;        // operand: 0 node price, 1 row start price
    logic set_start;   // row start price <= product
    logic leaf_wr;     // write leaf payoff at node index
    logic mix_go;      // compute and write back node j
  } crr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mul_done;
    logic mix_done;
  } crr_sts_t;

endpackage

// File: hdl/crr_if.sv
interface crr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] spot_price;
  logic [31:0] strike_price;
  modport source (output valid, spot_price, strike_price, input ready);
  modport sink (input valid, spot_price, strike_price, output ready);
endinterface

interface crr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] option_value;
  logic        saturated;
  modport source (output valid, option_value, saturated, input ready);
  modport sink (input valid, option_value, saturated, output ready);
endinterface

interface crr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/crr_ram.sv
module crr_ram #(
  parameter int Width = 32,
  parameter int Depth = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/crr_datapath.sv
module crr_datapath #(
  parameter int MaxSteps = crr_pkg::MaxStepsDefault,
  localparam int AddrW = $clog2(MaxSteps + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  crr_pkg::crr_cmd_t       cmd,
  output crr_pkg::crr_sts_t       sts,
  input  logic [AddrW-1:0]        node_idx,
  input  logic [31:0]             spot,
  input  logic [31:0]             strike,
  input  logic [31:0]             up_f,
  input  logic [31:0]             down_f,
  input  logic [31:0]             ratio_f,
  input  logic [31:0]             prob,
  input  logic [31:0]             disc,
  output logic [31:0]             root_value,
  output logic                    sat
);
  logic [31:0] strike_r, price_r, start_r;
  logic        sat_r;
  logic [31:0] factor, operand;
  logic [63:0] prod_r;
  logic        mul_busy_r, mul_done_r;
  logic [31:0] p_clip, disc_clip;
  logic [32:0] q_w;

  // two-port value memory: one 32-bit port for each child
  logic        we;
  logic [AddrW-1:0] waddr;
  logic [31:0] wdata, rd_lo, rd_hi;
  logic [AddrW-1:0] raddr_hi;

  assign p_clip    = (prob > 32'h8000_0000) ? 32'h8000_0000 : prob;
  assign disc_clip = (disc > 32'h8000_0000) ? 32'h8000_0000 : disc;
  assign q_w       = 33'h0_8000_0000 - {1'b0, p_clip};

  always_comb begin
    case (cmd.fsel)
      crr_pkg::FSEL_DOWN:  factor = down_f;
      crr_pkg::FSEL_RATIO: factor = ratio_f;
      default:             factor = up_f;
    endcase
    operand = cmd.psel ? start_r : price_r;
  end

  function automatic logic [31:0] payoff(input logic [31:0] k, input logic [31:0] s);
    payoff = (k > s) ? k - s : 32'd0;
  endfunction

  // price multiply: product registered, clip next cycle
  logic [33:0] scaled_hi;
  logic [31:0] scaled;
  logic        scaled_sat;
  assign scaled_hi  = prod_r[63:30];
  assign scaled_sat = |scaled_hi[33:32];
  assign scaled     = scaled_sat ? 32'hFFFF_FFFF : scaled_hi[31:0];

  // mix pipeline: read, weight products, sum, discount
  logic        s0_r, s1_r, s2_r, s3_r;
  logic [63:0] pa_r, qb_r;
  logic [31:0] mix_r;
  logic [63:0] held_r;
  logic [31:0] ex_r, ex2_r;
  logic [AddrW-1:0] a1_r, a2_r, a3_r, a4_r;
  logic [63:0] mix_sum;
  assign mix_sum = pa_r + qb_r;

  assign raddr_hi = node_idx + AddrW'(1);
  assign we    = cmd.leaf_wr || s3_r;
  assign waddr = cmd.leaf_wr ? node_idx : a4_r;
  assign wdata = cmd.leaf_wr ? payoff(strike_r, price_r)
               : ((held_r[63:31] > {1'b0, ex2_r}) ? held_r[62:31] : ex2_r);

  crr_ram #(.Width(32), .Depth(MaxSteps + 1)) u_lo (
    .clk, .we, .waddr, .wdata, .raddr(node_idx), .rdata(rd_lo));
  crr_ram #(.Width(32), .Depth(MaxSteps + 1)) u_hi (
    .clk, .we, .waddr, .wdata, .raddr(raddr_hi), .rdata(rd_hi));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strike_r <= '0; price_r <= '0; start_r <= '0;
      sat_r <= 1'b0; mul_busy_r <= 1'b0; mul_done_r <= 1'b0;
      s0_r <= 1'b0; s1_r <= 1'b0; s2_r <= 1'b0; s3_r <= 1'b0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.start) begin
        strike_r <= strike; price_r <= spot; sat_r <= 1'b0;
      end
      if (cmd.mul_go) begin
        prod_r <= 64'(operand) * 64'(factor);
        mul_busy_r <= 1'b1;
      end else if (mul_busy_r) begin
        mul_busy_r <= 1'b0;
        mul_done_r <= 1'b1;
        price_r <= scaled;
        if (cmd.set_start) start_r <= scaled;
        if (scaled_sat) sat_r <= 1'b1;
      end
      // mix pipeline
      s0_r <= cmd.mix_go;
      a1_r <= node_idx;
      if (cmd.mix_go) ex_r <= payoff(strike_r, price_r);
      s1_r <= s0_r; a2_r <= a1_r;
      pa_r <= 64'(p_clip) * 64'(rd_hi);
      qb_r <= 64'(q_w[31:0]) * 64'(rd_lo) + (q_w[32] ? {rd_lo, 32'd0} : 64'd0);
      ex2_r <= ex_r;
      s2_r <= s1_r; a3_r <= a2_r;
      mix_r <= mix_sum[62:31];
      s3_r <= s2_r; a4_r <= a3_r;
      held_r <= 64'(mix_r) * 64'(disc_clip);
    end
  end

  assign sts.mul_done = mul_done_r;
  assign sts.mix_done = s3_r;
  assign root_value   = rd_lo;
  assign sat          = sat_r;
endmodule

// File: hdl/crr_ctrl.sv
module crr_ctrl #(
  parameter int MaxSteps = crr_pkg::MaxStepsDefault,
  localparam int AddrW = $clog2(MaxSteps + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic [10:0]       steps,
  output crr_pkg::crr_cmd_t cmd,
  input  crr_pkg::crr_sts_t sts,
  output logic [AddrW-1:0]  node_idx
);
  typedef enum logic [3:0] {
    S_IDLE, S_DOWN, S_DOWN_W, S_LEAF, S_LEAF_W, S_ROW, S_ROW_W,
    S_MIX, S_MIX_W, S_STEP_W, S_RD, S_RD_W, S_OUT
  } state_t;

  state_t state_r;
  logic [AddrW-1:0] n_r, k_r, j_r, row_r;
  logic [AddrW-1:0] n_clip;

  assign n_clip = (int'(steps) > MaxSteps) ? AddrW'(MaxSteps) : AddrW'(steps);

  always_comb begin
    cmd = '0;
    cmd.start     = (state_r == S_IDLE) && in_valid;
    cmd.fsel      = crr_pkg::FSEL_RATIO;
    unique case (state_r)
      S_DOWN:  begin cmd.mul_go = 1'b1; cmd.fsel = crr_pkg::FSEL_DOWN; end
      S_DOWN_W: begin cmd.fsel = crr_pkg::FSEL_DOWN; cmd.set_start = 1'b1; end
      S_LEAF:  begin cmd.leaf_wr = 1'b1; cmd.mul_go = (j_r != n_r); end
      S_ROW:   begin cmd.mul_go = 1'b1; cmd.fsel = crr_pkg::FSEL_UP; cmd.psel = 1'b1; end
      S_ROW_W: begin cmd.fsel = crr_pkg::FSEL_UP; cmd.set_start = 1'b1; end
      S_MIX:   cmd.mix_go = 1'b1;
      // next node price once the write-back is done
      S_MIX_W: cmd.mul_go = (j_r != row_r) && sts.mix_done;
      default: ;
    endcase
  end

  assign node_idx  = j_r;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r <= '0; k_r <= '0; j_r <= '0; row_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          n_r <= n_clip; k_r <= '0; j_r <= '0;
          state_r <= (n_clip == '0) ? S_LEAF : S_DOWN;
        end
        S_DOWN: state_r <= S_DOWN_W;
        S_DOWN_W: if (sts.mul_done) begin
          k_r <= k_r + AddrW'(1);
          state_r <= (k_r + AddrW'(1) == n_r) ? S_LEAF : S_DOWN;
        end
        S_LEAF: begin
          if (j_r == n_r) begin
            row_r <= n_r; state_r <= (n_r == '0) ? S_RD : S_ROW;
          end else state_r <= S_LEAF_W;
        end
        S_LEAF_W: if (sts.mul_done) begin
          j_r <= j_r + AddrW'(1); state_r <= S_LEAF;
        end
        S_ROW: begin row_r <= row_r - AddrW'(1); j_r <= '0; state_r <= S_ROW_W; end
        S_ROW_W: if (sts.mul_done) state_r <= S_MIX;
        // read address j held during mix pipeline entry
        S_MIX: state_r <= S_MIX_W;
        S_MIX_W: if (sts.mix_done) begin
          if (j_r == row_r) begin
            j_r <= '0; state_r <= (row_r == '0) ? S_RD : S_ROW;
          end else state_r <= S_STEP_W;
        end
        S_STEP_W: if (sts.mul_done) begin
          j_r <= j_r + AddrW'(1); state_r <= S_MIX;
        end
        S_RD: begin j_r <= '0; state_r <= S_RD_W; end
        S_RD_W: state_r <= S_OUT;
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/american_put_binomial_pricer.sv
// American put pricer on a CRR binomial tree, one option at a time.
// From accept to result valid: the down multiplies, then each leaf word with a
// price multiply between leaves, then per row an up multiply for the row start
// price and per node: read, weights, sum, discount, write-back and, but for a
// row's last node, the next price multiply. Then the read of the root.
// Input not ready while busy or while a result waits. Synchronous active-low
// reset: idle controller, control and config registers at reset values.
module american_put_binomial_pricer #(
  parameter int MaxSteps = crr_pkg::MaxStepsDefault
) (
  input  logic clk,
  input  logic rst_n,
  crr_in_if.sink    in_ch,
  crr_out_if.source out_ch,
  crr_cfg_if.sink   cfg_ch
);
  localparam int AddrW = $clog2(MaxSteps + 1);

  logic [10:0] steps_r;
  logic [31:0] up_r, down_r, ratio_r, prob_r, disc_r;
  crr_pkg::crr_cmd_t cmd;
  crr_pkg::crr_sts_t sts;
  logic [AddrW-1:0] node_idx;
  logic [31:0] root;
  logic sat;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= 11'd1000; up_r <= 32'h4000_0000; down_r <= 32'h4000_0000;
      ratio_r <= 32'h4000_0000; prob_r <= 32'h4000_0000; disc_r <= 32'h8000_0000;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        crr_pkg::REG_STEPS: steps_r <= cfg_ch.data[10:0];
        crr_pkg::REG_UP:    up_r    <= cfg_ch.data;
        crr_pkg::REG_DOWN:  down_r  <= cfg_ch.data;
        crr_pkg::REG_RATIO: ratio_r <= cfg_ch.data;
        crr_pkg::REG_PROB:  prob_r  <= cfg_ch.data;
        crr_pkg::REG_DISC:  disc_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  crr_ctrl #(.MaxSteps(MaxSteps)) u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .steps(steps_r),
    .cmd, .sts, .node_idx);

  crr_datapath #(.MaxSteps(MaxSteps)) u_dp (
    .clk, .rst_n, .cmd, .sts, .node_idx, .spot(in_ch.spot_price),
    .strike(in_ch.strike_price), .up_f(up_r), .down_f(down_r),
    .ratio_f(ratio_r), .prob(prob_r), .disc(disc_r),
    .root_value(root), .sat);

  assign out_ch.option_value = root;
  assign out_ch.saturated    = sat;

  // result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.option_value))
    else $error("result changed under stall");
  // no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while result pending");
endmodule
